// ===== sv/cwnms_pkg.sv =====
// Shared types and constants for the class-wise box NMS unit.
package cwnms_pkg;

	localparam int MaxBoxesDef = 64;
	localparam logic [16:0] OneQ16 = 17'h10000;

	// One stored detection
	typedef struct packed {
		logic [16:0] score;
		logic [7:0]  cls;
		logic [15:0] height;
		logic [15:0] width;
		logic [15:0] top;
		logic [15:0] left;
		logic [16:0] limit;
		logic [5:0]  arrival;
	} rec_t;

	localparam int RecW = $bits(rec_t);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_INS_CMP, ST_INS_PUT, ST_POST,
		ST_SEL_RDI, ST_SEL_LDI, ST_SEL_J, ST_SEL_CHK, ST_SEL_IOU,
		ST_EM_RD, ST_EM_CHK, ST_EM_END
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic        capture;
		logic        re;
		logic [5:0]  raddr;
		logic        we;
		logic [5:0]  waddr;
		logic        wsel_new;
		logic        load_i;
		logic        iou_go;
		logic        pend_load;
		logic        fire;
		logic        fire_last;
		logic        fire_empty;
		logic        overflow;
		logic [5:0]  arrival;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pass_conf;
		logic item_last;
		logic rd_score_lt;
		logic class_eq;
		logic lim_dis;
		logic iou_hit;
	} dp_stat_t;

endpackage

// ===== sv/classwise_box_nms_unit.sv =====
// Top level of the class-wise greedy box NMS unit.
//
//  channel  handshake             beat contents
//  input    start & !busy         det_class score left top width height
//                                 conf_limit iou_limit last
//  result   done (one cycle)      valid_res index class_out score_out left_out
//                                 top_out width_out height_out overflow last_out
//
// Inserting a beat moves each lower-score box (up to MAX_BOXES-1) down one place
// through the store write port. In selection, a box with an active limit is tested
// against each kept earlier box, with an IoU test for each same-class one; emit then
// reads every stored box in turn.
// Results leave at most one per cycle; the receiver cannot stall them.
// arst_n clears the set state; the box store itself is not cleared.
module classwise_box_nms_unit
	import cwnms_pkg::*;
#(
	parameter int MAX_BOXES = MaxBoxesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  det_class,
	input  logic [16:0] score,
	input  logic [15:0] left,
	input  logic [15:0] top,
	input  logic [15:0] width,
	input  logic [15:0] height,
	input  logic [16:0] conf_limit,
	input  logic [16:0] iou_limit,
	input  logic        last,
	output logic        done,
	output logic        valid_res,
	output logic [5:0]  index,
	output logic [7:0]  class_out,
	output logic [16:0] score_out,
	output logic [15:0] left_out,
	output logic [15:0] top_out,
	output logic [15:0] width_out,
	output logic [15:0] height_out,
	output logic        overflow,
	output logic        last_out
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	cwnms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	cwnms_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.det_class  (det_class),
		.score      (score),
		.left       (left),
		.top        (top),
		.width      (width),
		.height     (height),
		.conf_limit (conf_limit),
		.iou_limit  (iou_limit),
		.last       (last),
		.done       (done),
		.valid_res  (valid_res),
		.index      (index),
		.class_out  (class_out),
		.score_out  (score_out),
		.left_out   (left_out),
		.top_out    (top_out),
		.width_out  (width_out),
		.height_out (height_out),
		.overflow   (overflow),
		.last_out   (last_out)
	);
endmodule

// ===== sv/cwnms_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cwnms_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/cwnms_dp.sv =====
// Datapath: item register, box store, IoU pipeline and result registers.
module cwnms_dp
	import cwnms_pkg::*;
#(
	parameter int MAX_BOXES = MaxBoxesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_stat_t    stat,
	input  logic [7:0]  det_class,
	input  logic [16:0] score,
	input  logic [15:0] left,
	input  logic [15:0] top,
	input  logic [15:0] width,
	input  logic [15:0] height,
	input  logic [16:0] conf_limit,
	input  logic [16:0] iou_limit,
	input  logic        last,
	output logic        done,
	output logic        valid_res,
	output logic [5:0]  index,
	output logic [7:0]  class_out,
	output logic [16:0] score_out,
	output logic [15:0] left_out,
	output logic [15:0] top_out,
	output logic [15:0] width_out,
	output logic [15:0] height_out,
	output logic        overflow,
	output logic        last_out
);
	localparam int AW = $clog2(MAX_BOXES);

	rec_t        item_q;
	logic [16:0] conf_q;
	logic        last_q;
	rec_t        new_rec, rdata, wdata, rec_i_q, pend_q;

	// Input beat capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q.score   <= score;
			item_q.cls     <= det_class;
			item_q.left    <= left;
			item_q.top     <= top;
			item_q.width   <= width;
			item_q.height  <= height;
			item_q.limit   <= iou_limit;
			item_q.arrival <= '0;
			conf_q         <= conf_limit;
			last_q         <= last;
		end
	end

	always_comb begin
		new_rec         = item_q;
		new_rec.arrival = cmd.arrival;
		wdata           = cmd.wsel_new ? new_rec : rdata;
	end

	cwnms_ram #(.Width(RecW), .Depth(MAX_BOXES)) u_store (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (cmd.waddr[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.re),
		.raddr (cmd.raddr[AW-1:0]),
		.rdata (rdata)
	);

	// Candidate box and pending result
	always_ff @(posedge clk) begin
		if (cmd.load_i) begin
			rec_i_q <= rdata;
		end
		if (cmd.pend_load) begin
			pend_q <= rdata;
		end
	end

	// IoU pipeline, stage 1: overlap extents
	logic [16:0] ax2, bx2, ay2, by2, x2, y2;
	logic [15:0] x1, y1;
	logic [16:0] iw_s1, ih_s1, lim_s1;
	logic [15:0] aw_s1, ah_s1, bw_s1, bh_s1;
	always_comb begin
		ax2 = {1'b0, rdata.left} + {1'b0, rdata.width};
		bx2 = {1'b0, rec_i_q.left} + {1'b0, rec_i_q.width};
		ay2 = {1'b0, rdata.top} + {1'b0, rdata.height};
		by2 = {1'b0, rec_i_q.top} + {1'b0, rec_i_q.height};
		x1  = (rdata.left > rec_i_q.left) ? rdata.left : rec_i_q.left;
		y1  = (rdata.top > rec_i_q.top) ? rdata.top : rec_i_q.top;
		x2  = (ax2 < bx2) ? ax2 : bx2;
		y2  = (ay2 < by2) ? ay2 : by2;
	end
	always_ff @(posedge clk) begin
		if (cmd.iou_go) begin
			iw_s1  <= (x2 > {1'b0, x1}) ? (x2 - {1'b0, x1}) : 17'd0;
			ih_s1  <= (y2 > {1'b0, y1}) ? (y2 - {1'b0, y1}) : 17'd0;
			aw_s1  <= rdata.width;
			ah_s1  <= rdata.height;
			bw_s1  <= rec_i_q.width;
			bh_s1  <= rec_i_q.height;
			lim_s1 <= rec_i_q.limit;
		end
	end

	// Stages 2 to 5: areas, union, split limit product, compare
	logic [33:0] inter_s2, inter_s3, inter_s4, uni_s3;
	logic [31:0] aa_s2, ab_s2;
	logic [16:0] lim_s2, lim_s3;
	logic [33:0] pl_s4, ph_s4;
	logic        uz_s4, hit_s5;
	logic [51:0] lhs, rhs;
	always_ff @(posedge clk) begin
		inter_s2 <= iw_s1 * ih_s1;
		aa_s2    <= aw_s1 * ah_s1;
		ab_s2    <= bw_s1 * bh_s1;
		lim_s2   <= lim_s1;
		uni_s3   <= {2'b0, aa_s2} + {2'b0, ab_s2} - inter_s2;
		inter_s3 <= inter_s2;
		lim_s3   <= lim_s2;
		pl_s4    <= lim_s3 * uni_s3[16:0];
		ph_s4    <= lim_s3 * uni_s3[33:17];
		uz_s4    <= (uni_s3 == 34'd0);
		inter_s4 <= inter_s3;
		hit_s5   <= !uz_s4 && (lhs > rhs);
	end
	assign lhs = {2'b0, inter_s4, 16'd0};
	assign rhs = {1'b0, ph_s4, 17'd0} + {18'd0, pl_s4};

	// Status
	always_comb begin
		stat.pass_conf   = item_q.score >= conf_q;
		stat.item_last   = last_q;
		stat.rd_score_lt = rdata.score < item_q.score;
		stat.class_eq    = rdata.cls == rec_i_q.cls;
		stat.lim_dis     = rdata.limit >= OneQ16;
		stat.iou_hit     = hit_s5;
	end

	// Result beat registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.fire;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			valid_res  <= !cmd.fire_empty;
			index      <= cmd.fire_empty ? 6'd0 : pend_q.arrival;
			class_out  <= cmd.fire_empty ? 8'd0 : pend_q.cls;
			score_out  <= cmd.fire_empty ? 17'd0 : pend_q.score;
			left_out   <= cmd.fire_empty ? 16'd0 : pend_q.left;
			top_out    <= cmd.fire_empty ? 16'd0 : pend_q.top;
			width_out  <= cmd.fire_empty ? 16'd0 : pend_q.width;
			height_out <= cmd.fire_empty ? 16'd0 : pend_q.height;
			overflow   <= cmd.overflow;
			last_out   <= cmd.fire_last;
		end
	end
endmodule

// ===== sv/cwnms_ctrl.sv =====
// Controller: load, insertion, suppression and emit sequencing.
module cwnms_ctrl
	import cwnms_pkg::*;
#(
	parameter int MAX_BOXES = MaxBoxesDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);
	localparam int AW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	state_t               state_q, state_d;
	logic [CW-1:0]        cnt_q;
	logic [6:0]           arr_q;
	logic [5:0]           arr_item_q;
	logic                 ovf_q, pend_v_q;
	logic [MAX_BOXES-1:0] kept_q;
	logic [AW-1:0]        i_q, j_q, cnt_m1, i_p1;
	logic [2:0]           step_q;
	logic                 i_last, j_last, full, iou_end;
	logic                 adv_j, sup, i_adv, keep_ldi;

	// Loop bookkeeping
	always_comb begin
		cnt_m1   = AW'(cnt_q - CW'(1));
		i_p1     = AW'(i_q + AW'(1));
		i_last   = (CW'(i_q) + CW'(1)) == cnt_q;
		j_last   = AW'(j_q + AW'(1)) == i_q;
		full     = cnt_q >= CW'(MAX_BOXES);
		iou_end  = (state_q == ST_SEL_IOU) && (step_q == 3'd4);
		keep_ldi = (state_q == ST_SEL_LDI) && ((i_q == '0) || stat.lim_dis);
		adv_j    = ((state_q == ST_SEL_J) && !kept_q[j_q]) ||
		           ((state_q == ST_SEL_CHK) && !stat.class_eq) ||
		           (iou_end && !stat.iou_hit);
		sup      = iou_end && stat.iou_hit;
		i_adv    = keep_ldi || (adv_j && j_last) || sup;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (stat.pass_conf && !full && (cnt_q != '0)) state_d = ST_INS_CMP;
				else state_d = ST_POST;
			end
			ST_INS_CMP: begin
				if (!stat.rd_score_lt) state_d = ST_POST;
				else if (i_q == '0) state_d = ST_INS_PUT;
			end
			ST_INS_PUT: state_d = ST_POST;
			ST_POST: begin
				if (!stat.item_last) state_d = ST_IDLE;
				else if (cnt_q == '0) state_d = ST_EM_END;
				else state_d = ST_SEL_RDI;
			end
			ST_SEL_RDI: state_d = ST_SEL_LDI;
			ST_SEL_LDI, ST_SEL_J, ST_SEL_CHK, ST_SEL_IOU: begin
				if (i_adv) state_d = i_last ? ST_EM_RD : ST_SEL_RDI;
				else if (adv_j) state_d = ST_SEL_J;
				else if (state_q == ST_SEL_LDI) state_d = ST_SEL_J;
				else if (state_q == ST_SEL_J) state_d = ST_SEL_CHK;
				else if (state_q == ST_SEL_CHK) state_d = ST_SEL_IOU;
			end
			ST_EM_RD:   state_d = ST_EM_CHK;
			ST_EM_CHK:  state_d = i_last ? ST_EM_END : ST_EM_RD;
			ST_EM_END:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.overflow = ovf_q;
		cmd.arrival  = arr_item_q;
		unique case (state_q)
			ST_IDLE: cmd.capture = start;
			ST_DECIDE: begin
				if (stat.pass_conf && !full) begin
					if (cnt_q != '0) begin
						cmd.re    = 1'b1;
						cmd.raddr = 6'(cnt_m1);
					end else begin
						cmd.we       = 1'b1;
						cmd.wsel_new = 1'b1;
					end
				end
			end
			ST_INS_CMP: begin
				cmd.we    = 1'b1;
				cmd.waddr = 6'(i_p1);
				if (stat.rd_score_lt) begin
					cmd.re    = (i_q != '0);
					cmd.raddr = 6'(AW'(i_q - AW'(1)));
				end else begin
					cmd.wsel_new = 1'b1;
				end
			end
			ST_INS_PUT: begin
				cmd.we       = 1'b1;
				cmd.wsel_new = 1'b1;
			end
			ST_SEL_RDI, ST_EM_RD: begin
				cmd.re    = 1'b1;
				cmd.raddr = 6'(i_q);
			end
			ST_SEL_LDI: cmd.load_i = 1'b1;
			ST_SEL_J: begin
				cmd.re    = kept_q[j_q];
				cmd.raddr = 6'(j_q);
			end
			ST_SEL_CHK: cmd.iou_go = stat.class_eq;
			ST_EM_CHK: begin
				cmd.pend_load = kept_q[i_q];
				cmd.fire      = kept_q[i_q] && pend_v_q;
			end
			ST_EM_END: begin
				cmd.fire       = 1'b1;
				cmd.fire_last  = 1'b1;
				cmd.fire_empty = !pend_v_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Counters, flags and set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			arr_q      <= '0;
			arr_item_q <= '0;
			ovf_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			kept_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			step_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				arr_item_q <= arr_q[5:0];
				arr_q      <= arr_q + 7'd1;
			end
			if (state_q == ST_DECIDE && stat.pass_conf) begin
				if (full) ovf_q <= 1'b1;
				else if (cnt_q == '0) cnt_q <= cnt_q + CW'(1);
				else i_q <= cnt_m1;
			end
			if (state_q == ST_INS_CMP) begin
				if (!stat.rd_score_lt) cnt_q <= cnt_q + CW'(1);
				else if (i_q != '0) i_q <= AW'(i_q - AW'(1));
			end
			if (state_q == ST_INS_PUT) cnt_q <= cnt_q + CW'(1);
			if (state_q == ST_POST) i_q <= '0;
			if (state_q == ST_SEL_LDI) j_q <= '0;
			if (state_q == ST_SEL_CHK) step_q <= '0;
			if (state_q == ST_SEL_IOU) step_q <= step_q + 3'd1;
			if (adv_j && !j_last) j_q <= AW'(j_q + AW'(1));
			if (keep_ldi || (adv_j && j_last)) kept_q[i_q] <= 1'b1;
			if (sup) kept_q[i_q] <= 1'b0;
			if (i_adv) i_q <= i_last ? '0 : i_p1;
			if (state_q == ST_EM_CHK) begin
				if (kept_q[i_q]) pend_v_q <= 1'b1;
				if (!i_last) i_q <= i_p1;
			end
			if (state_q == ST_EM_END) begin
				kept_q   <= '0;
				cnt_q    <= '0;
				arr_q    <= '0;
				ovf_q    <= 1'b0;
				pend_v_q <= 1'b0;
				i_q      <= '0;
			end
		end
	end
endmodule

// ===== bench/classwise_box_nms_unit_test.sv =====
// Testbench for the class-wise box NMS unit: directed table, an overflow set and random sets.
`timescale 1ns / 100ps

module classwise_box_nms_unit_test;
	import cwnms_pkg::*;

	localparam int CAP = MaxBoxesDef;
	localparam int CYCLE_LIMIT = 3000000;

	// One detection beat
	typedef struct {
		logic [7:0]  cls;
		logic [16:0] score;
		logic [15:0] left, top, width, height;
		logic [16:0] conf, iou;
		logic        last;
	} det_t;

	// One kept-box result
	typedef struct {
		logic        valid_res;
		logic [5:0]  index;
		logic [7:0]  cls;
		logic [16:0] score;
		logic [15:0] left, top, width, height;
		logic        overflow;
		logic        last;
	} kept_t;

	// Directed row: beat plus an optional typed-in expectation
	typedef struct {
		det_t  d;
		bit    has_exp;
		kept_t e;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic [7:0]  det_class = 0;
	logic [16:0] score = 0, conf_limit = 0, iou_limit = 0;
	logic [15:0] left = 0, top = 0, width = 0, height = 0;
	logic last = 0;
	logic valid_res, overflow, last_out;
	logic [5:0]  index;
	logic [7:0]  class_out;
	logic [16:0] score_out;
	logic [15:0] left_out, top_out, width_out, height_out;

	int mismatches = 0;
	int cycles = 0;
	kept_t survivors_due[$];

	// Predictor state: sorted store of one set
	det_t        sorted_det[CAP];
	logic [5:0]  sorted_arr[CAP];
	bit          kept[CAP];
	int          n_stored = 0;
	logic [6:0]  n_arrived = 0;
	bit          ovf = 0;

	classwise_box_nms_unit DUT (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report(input string what);
		mismatches++;
		$display("MISMATCH t=%0t %s", $realtime, what);
	endtask

	// Cross-multiplied IoU test of candidate b against kept box a
	function automatic bit iou_above(det_t a, det_t b, logic [16:0] lim);
		longint unsigned x1, y1, x2, y2, inter, uni;
		x1 = (a.left > b.left) ? a.left : b.left;
		y1 = (a.top > b.top) ? a.top : b.top;
		x2 = ((64'(a.left) + a.width) < (64'(b.left) + b.width)) ?
			64'(a.left) + a.width : 64'(b.left) + b.width;
		y2 = ((64'(a.top) + a.height) < (64'(b.top) + b.height)) ?
			64'(a.top) + a.height : 64'(b.top) + b.height;
		inter = 0;
		if (x2 > x1 && y2 > y1)
			inter = (x2 - x1) * (y2 - y1);
		uni = 64'(a.width) * a.height + 64'(b.width) * b.height - inter;
		if (uni == 0)
			return 0;
		return inter * 65536 > 64'(lim) * uni;
	endfunction

	// Load one beat into the predicted store; on last, queue the survivors
	task automatic predict_nms(input det_t d);
		int pos, nk;
		bit sup;
		kept_t k;
		logic [5:0] arr;
		arr = n_arrived[5:0];
		n_arrived = n_arrived + 1;
		if (d.score >= d.conf) begin
			if (n_stored >= CAP)
				ovf = 1;
			else begin
				pos = n_stored;
				for (int i = 0; i < n_stored; i++)
					if (sorted_det[i].score < d.score) begin
						pos = i;
						break;
					end
				for (int i = n_stored; i > pos; i--) begin
					sorted_det[i] = sorted_det[i-1];
					sorted_arr[i] = sorted_arr[i-1];
				end
				sorted_det[pos] = d;
				sorted_arr[pos] = arr;
				n_stored++;
			end
		end
		if (!d.last)
			return;
		nk = 0;
		for (int i = 0; i < n_stored; i++) begin
			sup = 0;
			for (int j = 0; j < i && !sup; j++)
				if (kept[j] && sorted_det[j].cls == sorted_det[i].cls &&
					sorted_det[i].iou < OneQ16 &&
					iou_above(sorted_det[j], sorted_det[i], sorted_det[i].iou))
					sup = 1;
			kept[i] = !sup;
		end
		for (int i = 0; i < n_stored; i++) begin
			if (!kept[i])
				continue;
			k.valid_res = 1;
			k.index = sorted_arr[i];
			k.cls = sorted_det[i].cls;
			k.score = sorted_det[i].score;
			k.left = sorted_det[i].left;
			k.top = sorted_det[i].top;
			k.width = sorted_det[i].width;
			k.height = sorted_det[i].height;
			k.overflow = ovf;
			k.last = 0;
			survivors_due.insert(survivors_due.size(), k);
			nk++;
		end
		if (nk == 0) begin
			k = '{default: 0};
			k.overflow = ovf;
			k.last = 1;
			survivors_due.insert(survivors_due.size(), k);
		end else
			survivors_due[$].last = 1;
		n_stored = 0;
		n_arrived = 0;
		ovf = 0;
		for (int i = 0; i < CAP; i++)
			kept[i] = 0;
	endtask

	// Result checker at the rising edge
	always @(posedge clk) begin
		kept_t e;
		if (arst_n && done) begin
			if (survivors_due.size() == 0)
				report("result with none expected");
			else begin
				e = survivors_due.pop_front();
				if (valid_res !== e.valid_res) report("valid_res");
				if (index !== e.index) report($sformatf("index %0d exp %0d", index, e.index));
				if (class_out !== e.cls) report("class_out");
				if (score_out !== e.score) report("score_out");
				if (left_out !== e.left) report("left_out");
				if (top_out !== e.top) report("top_out");
				if (width_out !== e.width) report("width_out");
				if (height_out !== e.height) report("height_out");
				if (overflow !== e.overflow) report("overflow");
				if (last_out !== e.last) report("last_out");
			end
		end
	end

	bit idle_on = 1;

	// Drive one beat at the falling edge, hold until accepted
	task automatic send_beat(input det_t d);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 34) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		det_class <= d.cls;
		score <= d.score;
		left <= d.left;
		top <= d.top;
		width <= d.width;
		height <= d.height;
		conf_limit <= d.conf;
		iou_limit <= d.iou;
		last <= d.last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_nms(d);
		@(negedge clk);
		start <= 0;
	endtask

	function automatic det_t mk(logic [7:0] c, logic [16:0] s, logic [15:0] l,
		logic [15:0] t, logic [15:0] w, logic [15:0] h, logic [16:0] cf,
		logic [16:0] io, logic la);
		det_t d;
		d.cls = c; d.score = s; d.left = l; d.top = t; d.width = w;
		d.height = h; d.conf = cf; d.iou = io; d.last = la;
		return d;
	endfunction

	// Random box; tight clusters so overlaps happen often
	function automatic det_t rand_det(bit la);
		det_t d;
		logic [31:0] r;
		r = $urandom;
		d.cls = (r[1:0] == 0) ? 8'($urandom) : 8'($urandom_range(2));
		d.score = (r[4:2] == 0) ? 17'($urandom) : 17'($urandom_range(65536));
		d.conf = (r[7:5] == 0) ? 17'($urandom) : 17'($urandom_range(20000));
		d.iou = (r[10:8] == 0) ? 17'($urandom) :
			(r[10:8] == 1) ? 17'd65536 : 17'($urandom_range(65535));
		if (r[13:11] == 0) begin
			d.left = 16'($urandom); d.top = 16'($urandom);
			d.width = 16'($urandom); d.height = 16'($urandom);
		end else begin
			d.left = 16'(1000 + $urandom_range(300));
			d.top = 16'(2000 + $urandom_range(300));
			d.width = 16'($urandom_range(600));
			d.height = 16'($urandom_range(600));
		end
		d.last = la;
		return d;
	endfunction

	// Wait for all survivors, then a quiet spell for trailing activity
	task automatic drain();
		while (survivors_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	row_t rows[$];
	row_t r;
	int set_len;

	initial begin
		// directed rows
		r = '{default: 0};
		// empty set: single box below confidence, nothing survives
		r.d = mk(8'd3, 17'd100, 0, 0, 16, 16, 17'd200, 17'd32768, 1);
		r.has_exp = 1; r.e = '{default: 0}; r.e.last = 1;
		rows.insert(rows.size(), r);
		// extremes of one lone box
		r.d = mk(8'hFF, 17'd65536, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			17'h1FFFF, 17'h1FFFF, 1);
		r.has_exp = 0; rows.insert(rows.size(), r);
		r.d = mk(8'hFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			17'h1FFFF, 17'h1FFFF, 1);
		r.has_exp = 1;
		r.e = '{1, 6'd0, 8'hFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1};
		rows.insert(rows.size(), r);
		r.has_exp = 0;
		// overlap suppressed, tie order, other class kept, disabled limit
		r.d = mk(1, 50000, 100, 100, 200, 200, 0, 17'd16384, 0); rows.insert(rows.size(), r);
		r.d = mk(1, 50000, 110, 110, 200, 200, 0, 17'd16384, 0); rows.insert(rows.size(), r);
		r.d = mk(2, 50000, 110, 110, 200, 200, 0, 17'd0, 0); rows.insert(rows.size(), r);
		r.d = mk(1, 60000, 105, 105, 200, 200, 0, 17'd65536, 0); rows.insert(rows.size(), r);
		// zero-area boxes with zero limit: empty union
		r.d = mk(4, 30000, 5, 5, 0, 0, 0, 17'd0, 0); rows.insert(rows.size(), r);
		r.d = mk(4, 29000, 5, 5, 0, 0, 0, 17'd0, 0); rows.insert(rows.size(), r);
		// score equal to its limit passes, zero score kept
		r.d = mk(5, 20000, 0, 0, 1, 1, 20000, 17'd1, 0); rows.insert(rows.size(), r);
		r.d = mk(6, 0, 0, 0, 1, 1, 0, 17'd0, 1); rows.insert(rows.size(), r);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		foreach (rows[i]) begin
			send_beat(rows[i].d);
			if (rows[i].has_exp) begin
				survivors_due.pop_back();
				survivors_due.insert(survivors_due.size(), rows[i].e);
			end
		end
		drain();

		// overflow: 70 passing boxes, arrival positions wrap
		for (int i = 0; i < 70; i++)
			send_beat(mk(8'(i % 3), 17'($urandom_range(65536)), 16'(i * 40), 0,
				30, 30, 0, 17'd65536, i == 69));
		drain();

		// random sets, with a stretch of no idling
		for (int sent = 0; sent < 390; ) begin
			idle_on = !(sent > 100 && sent < 200);
			set_len = ($urandom_range(15) == 0) ? $urandom_range(66, 80) :
				$urandom_range(1, 12);
			for (int k = 0; k < set_len; k++)
				send_beat(rand_det(k == set_len - 1));
			sent += set_len;
		end
		drain();

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== classwise_box_nms_unit.f =====
sv/cwnms_pkg.sv
sv/cwnms_ram.sv
sv/cwnms_dp.sv
sv/cwnms_ctrl.sv
sv/classwise_box_nms_unit.sv
bench/classwise_box_nms_unit_test.sv
